### rtl/gfba_pkg.sv
package gfba_pkg;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_LOAD,
        S_POP,
        S_POP_WAIT,
        S_PUSH,
        S_SP_HEAD,
        S_SP_BASE,
        S_SP_HDR0,
        S_SP_HDR1,
        S_SP_COPY,
        S_OUT
    } t_state;

    localparam logic [15:0] NO_GROUP      = 16'hFFFF;
    localparam int          GRP_CNT_W     = 5;
    localparam logic [4:0]  GRP_CNT_RESET = 5'd16;

endpackage

### rtl/grouped_free_block_allocator.sv
// Grouped free-list block allocator.
// Input channel: i_valid / o_stall carrying i_command and i_block_index.
// A request is taken when i_valid is high and o_stall is low; o_stall is high
// while a request is in progress, so one request is worked on at a time.
// Output channel: o_valid / i_stall, one result per request, held in an
// output register so the next request can start while a result waits.
// Requests that stream through the memories:
//   allocate needing a group reload streams one record word
//   per cycle through the group store read port;
//   free with spill streams one stack word per cycle into the store;
//   init writes one store word per cycle.
// The group store and the stack each have one write and one read port with
// a registered read.
// Reset (i_rst_n low, synchronous) empties the stack, clears the free count,
// sets no next group and group_count to 16; the store is not cleared and an
// init request must be issued before blocks are handed out.
// If the receiver stalls, the finished result waits in the output register
// and a following result waits in the block until the register empties.
module grouped_free_block_allocator #(
    parameter int GROUP_SIZE   = 16,
    parameter int TOTAL_BLOCKS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [4:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_block_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_granted_index,
    output logic       o_ok,
    output logic [8:0] o_remaining_blocks,
    output logic [4:0] o_free_in_group
);

    localparam int RW          = GROUP_SIZE + 2;
    localparam int STORE_DEPTH = TOTAL_BLOCKS * RW;
    localparam int SA_W        = $clog2(STORE_DEPTH);
    localparam int SK_W        = $clog2(GROUP_SIZE);
    localparam int CNT_W       = $clog2(GROUP_SIZE + 1);
    localparam int STEP_W      = $clog2(RW + 1);
    localparam int REM_W       = $clog2(TOTAL_BLOCKS + 1);
    localparam int MAXG        = TOTAL_BLOCKS / GROUP_SIZE;
    localparam int GRP_W       = $clog2(MAXG + 1);

    gfba_pkg::t_state r_state, n_state;

    logic [gfba_pkg::GRP_CNT_W-1:0] r_group_count;
    logic [CNT_W-1:0]  r_count;
    logic [15:0]       r_next;
    logic [REM_W-1:0]  r_remaining;
    logic [7:0]        r_idx;
    logic [7:0]        r_head;
    logic [GRP_W-1:0]  r_groups;
    logic [GRP_W-1:0]  r_grp;
    logic [15:0]       r_blk;
    logic [SA_W-1:0]   r_base;
    logic [STEP_W-1:0] r_step;
    logic              r_pend;
    logic [STEP_W-1:0] r_pend_step;
    logic [CNT_W-1:0]  r_ld_cnt;
    logic [7:0]        r_res_granted;
    logic              r_res_ok;
    logic              r_out_valid;
    logic [7:0]        r_out_granted;
    logic              r_out_ok;
    logic [8:0]        r_out_remaining;
    logic [4:0]        r_out_free;

    // memory ports
    logic              st_we, st_re;
    logic [SA_W-1:0]   st_waddr, st_raddr;
    logic [15:0]       st_wdata, st_rdata;
    logic              sk_we, sk_re;
    logic [SK_W-1:0]   sk_waddr, sk_raddr;
    logic [7:0]        sk_wdata, sk_rdata;

    logic              accept;
    logic              out_free;
    logic              issue;
    logic              last_grp;
    logic              init_last;
    logic              ld_done;
    logic              copy_done;
    logic              spill_ok;
    logic [GRP_W-1:0]  groups_eff;
    logic [15:0]       init_word;

    gfba_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    gfba_ram #(.WIDTH(8), .DEPTH(GROUP_SIZE)) u_stack (
        .i_clk   (i_clk),
        .i_we    (sk_we),
        .i_waddr (sk_waddr),
        .i_wdata (sk_wdata),
        .i_re    (sk_re),
        .i_raddr (sk_raddr),
        .o_rdata (sk_rdata)
    );

    assign accept    = (r_state == gfba_pkg::S_IDLE) && i_valid;
    assign out_free  = !r_out_valid || !i_stall;
    assign last_grp  = (r_grp == GRP_W'(r_groups - GRP_W'(1)));
    assign init_last = (r_step == STEP_W'(RW - 1)) && last_grp;
    assign ld_done   = r_pend && (r_pend_step == STEP_W'(RW - 1));
    assign copy_done = r_pend && (r_pend_step == STEP_W'(GROUP_SIZE - 1));
    assign spill_ok  = (32'(r_head) < TOTAL_BLOCKS);

    // zero counts as one group; saturate at what the store can hold
    always_comb begin
        if (r_group_count == '0) begin
            groups_eff = GRP_W'(1);
        end else if (32'(r_group_count) > MAXG) begin
            groups_eff = GRP_W'(MAXG);
        end else begin
            groups_eff = GRP_W'(r_group_count);
        end
    end

    always_comb begin
        if (r_step == STEP_W'(0)) begin
            init_word = 16'(GROUP_SIZE);
        end else if (r_step == STEP_W'(1)) begin
            init_word = last_grp ? gfba_pkg::NO_GROUP : 16'(32'(r_blk) + GROUP_SIZE);
        end else begin
            init_word = 16'(32'(r_blk) + 32'(r_step) - 32'd2);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gfba_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (gfba_pkg::t_cmd'(i_command))
                        gfba_pkg::CMD_INIT: n_state = gfba_pkg::S_INIT;
                        gfba_pkg::CMD_ALLOC: begin
                            if (r_count != '0) begin
                                n_state = gfba_pkg::S_POP;
                            end else if (32'(r_next) >= TOTAL_BLOCKS) begin
                                n_state = gfba_pkg::S_OUT;
                            end else begin
                                n_state = gfba_pkg::S_LOAD;
                            end
                        end
                        gfba_pkg::CMD_FREE: begin
                            n_state = (32'(r_count) >= GROUP_SIZE) ? gfba_pkg::S_SP_HEAD
                                                                   : gfba_pkg::S_PUSH;
                        end
                        default: n_state = gfba_pkg::S_OUT;
                    endcase
                end
            end
            gfba_pkg::S_INIT: begin
                if (init_last) n_state = gfba_pkg::S_OUT;
            end
            gfba_pkg::S_LOAD: begin
                if (ld_done) begin
                    n_state = (r_ld_cnt == '0) ? gfba_pkg::S_OUT : gfba_pkg::S_POP;
                end
            end
            gfba_pkg::S_POP:      n_state = gfba_pkg::S_POP_WAIT;
            gfba_pkg::S_POP_WAIT: n_state = gfba_pkg::S_OUT;
            gfba_pkg::S_PUSH:     n_state = gfba_pkg::S_OUT;
            gfba_pkg::S_SP_HEAD:  n_state = gfba_pkg::S_SP_BASE;
            gfba_pkg::S_SP_BASE:  n_state = gfba_pkg::S_SP_HDR0;
            gfba_pkg::S_SP_HDR0:  n_state = gfba_pkg::S_SP_HDR1;
            gfba_pkg::S_SP_HDR1:  n_state = gfba_pkg::S_SP_COPY;
            gfba_pkg::S_SP_COPY: begin
                if (copy_done) n_state = gfba_pkg::S_PUSH;
            end
            gfba_pkg::S_OUT: begin
                if (out_free) n_state = gfba_pkg::S_IDLE;
            end
            default: n_state = gfba_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        issue    = 1'b0;
        st_we    = 1'b0;
        st_waddr = r_base;
        st_wdata = 16'(GROUP_SIZE);
        st_re    = 1'b0;
        st_raddr = SA_W'(r_base + SA_W'(r_step));
        sk_we    = 1'b0;
        sk_waddr = SK_W'(r_count);
        sk_wdata = r_idx;
        sk_re    = 1'b0;
        sk_raddr = SK_W'(GROUP_SIZE - 1);
        unique case (r_state)
            gfba_pkg::S_INIT: begin
                st_we    = 1'b1;
                st_waddr = SA_W'(r_base + SA_W'(r_step));
                st_wdata = init_word;
                // group 0 goes straight into the stack as it is laid out
                if (r_grp == '0 && r_step >= STEP_W'(2)) begin
                    sk_we    = 1'b1;
                    sk_waddr = SK_W'(32'(r_step) - 32'd2);
                    sk_wdata = init_word[7:0];
                end
            end
            gfba_pkg::S_LOAD: begin
                issue = (32'(r_step) < RW);
                st_re = issue;
                if (r_pend && r_pend_step >= STEP_W'(2)
                        && (32'(r_pend_step) - 32'd2) < 32'(r_ld_cnt)) begin
                    sk_we    = 1'b1;
                    sk_waddr = SK_W'(32'(r_pend_step) - 32'd2);
                    sk_wdata = st_rdata[7:0];
                end
            end
            gfba_pkg::S_POP: begin
                sk_re    = 1'b1;
                sk_raddr = SK_W'(32'(r_count) - 32'd1);
            end
            gfba_pkg::S_PUSH: begin
                sk_we = 1'b1;
            end
            gfba_pkg::S_SP_HEAD: begin
                sk_re = 1'b1;
            end
            gfba_pkg::S_SP_HDR0: begin
                st_we = spill_ok;
            end
            gfba_pkg::S_SP_HDR1: begin
                st_we    = spill_ok;
                st_waddr = SA_W'(r_base + SA_W'(1));
                st_wdata = r_next;
            end
            gfba_pkg::S_SP_COPY: begin
                // top of stack goes into the first entry of the record
                issue    = (32'(r_step) < GROUP_SIZE);
                sk_re    = issue;
                sk_raddr = SK_W'(GROUP_SIZE - 1 - 32'(r_step));
                st_we    = r_pend && spill_ok;
                st_waddr = SA_W'(r_base + SA_W'(2) + SA_W'(r_pend_step));
                st_wdata = {8'd0, sk_rdata};
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gfba_pkg::S_IDLE;
            r_group_count <= gfba_pkg::GRP_CNT_RESET;
            r_count       <= '0;
            r_next        <= gfba_pkg::NO_GROUP;
            r_remaining   <= '0;
            r_out_valid   <= 1'b0;
            r_pend        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_group_count <= i_cfg_wr_data;
            end
            r_pend <= issue;
            if (r_state == gfba_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                gfba_pkg::S_INIT: begin
                    if (r_grp == '0 && r_step == STEP_W'(1)) begin
                        r_next <= init_word;
                    end
                    if (init_last) begin
                        r_count     <= CNT_W'(GROUP_SIZE);
                        r_remaining <= REM_W'(32'(r_blk) + GROUP_SIZE);
                    end
                end
                gfba_pkg::S_LOAD: begin
                    if (r_pend && r_pend_step == STEP_W'(1)) begin
                        r_next <= st_rdata;
                    end
                    if (ld_done) begin
                        r_count <= r_ld_cnt;
                    end
                end
                gfba_pkg::S_POP: begin
                    r_count <= CNT_W'(r_count - CNT_W'(1));
                end
                gfba_pkg::S_POP_WAIT: begin
                    if (r_remaining != '0) begin
                        r_remaining <= REM_W'(r_remaining - REM_W'(1));
                    end
                end
                gfba_pkg::S_PUSH: begin
                    r_count <= CNT_W'(r_count + CNT_W'(1));
                    if (32'(r_remaining) < TOTAL_BLOCKS) begin
                        r_remaining <= REM_W'(r_remaining + REM_W'(1));
                    end
                end
                gfba_pkg::S_SP_COPY: begin
                    if (copy_done) begin
                        r_next  <= {8'd0, r_head};
                        r_count <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_pend_step <= r_step;
        if (accept) begin
            r_idx         <= i_block_index;
            r_groups      <= groups_eff;
            r_grp         <= '0;
            r_blk         <= '0;
            r_step        <= '0;
            r_res_granted <= '0;
            r_res_ok      <= (gfba_pkg::t_cmd'(i_command) == gfba_pkg::CMD_INIT)
                          || (gfba_pkg::t_cmd'(i_command) == gfba_pkg::CMD_FREE);
            if (gfba_pkg::t_cmd'(i_command) == gfba_pkg::CMD_INIT) begin
                r_base <= '0;
            end else begin
                r_base <= SA_W'(32'(r_next) * 32'(RW));
            end
        end else begin
            unique case (r_state)
                gfba_pkg::S_INIT: begin
                    if (r_step == STEP_W'(RW - 1)) begin
                        r_step <= '0;
                        r_grp  <= GRP_W'(r_grp + GRP_W'(1));
                        r_blk  <= 16'(32'(r_blk) + GROUP_SIZE);
                        r_base <= SA_W'(32'(r_base) + GROUP_SIZE * RW);
                    end else begin
                        r_step <= STEP_W'(r_step + STEP_W'(1));
                    end
                end
                gfba_pkg::S_LOAD: begin
                    if (issue) begin
                        r_step <= STEP_W'(r_step + STEP_W'(1));
                    end
                    if (r_pend && r_pend_step == '0) begin
                        r_ld_cnt <= (32'(st_rdata) > GROUP_SIZE) ? CNT_W'(GROUP_SIZE)
                                                                : CNT_W'(st_rdata);
                    end
                end
                gfba_pkg::S_POP_WAIT: begin
                    r_res_granted <= sk_rdata;
                    r_res_ok      <= 1'b1;
                end
                gfba_pkg::S_SP_BASE: begin
                    r_head <= sk_rdata;
                    r_base <= SA_W'(32'(sk_rdata) * 32'(RW));
                    r_step <= '0;
                end
                gfba_pkg::S_SP_COPY: begin
                    if (issue) begin
                        r_step <= STEP_W'(r_step + STEP_W'(1));
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == gfba_pkg::S_OUT && out_free) begin
            r_out_granted   <= r_res_granted;
            r_out_ok        <= r_res_ok;
            r_out_remaining <= 9'(r_remaining);
            r_out_free      <= 5'(r_count);
        end
    end

    assign o_stall            = (r_state != gfba_pkg::S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_granted_index    = r_out_granted;
    assign o_ok               = r_out_ok;
    assign o_remaining_blocks = r_out_remaining;
    assign o_free_in_group    = r_out_free;

endmodule

### rtl/gfba_ram.sv
module gfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sv/grouped_free_block_allocator_test.sv
`timescale 1ns / 100ps
module grouped_free_block_allocator_test;

    typedef struct packed {
        logic [7:0] granted;
        logic       ok;
        logic [8:0] remaining;
        logic [4:0] in_group;
    } t_alloc_result;

    // Tracks the free-list state and the results still owed by the block.
    class free_list_tracker;
        localparam int GSIZE = 16;
        localparam int NBLK  = 256;
        localparam int REC   = GSIZE + 2;

        logic [4:0]    group_cfg;
        logic [7:0]    stack_q [GSIZE];
        int unsigned   depth;
        logic [15:0]   next_head;
        int unsigned   free_total;
        logic [15:0]   store [NBLK * REC];
        t_alloc_result expected_results [$];
        int unsigned   mismatches;

        function new();
            group_cfg  = gfba_pkg::GRP_CNT_RESET;
            depth      = 0;
            next_head  = gfba_pkg::NO_GROUP;
            free_total = 0;
            mismatches = 0;
            foreach (stack_q[k]) stack_q[k] = '0;
            foreach (store[k]) store[k] = '0;
        endfunction

        function void load_group(int unsigned head);
            int unsigned base, cnt, k;
            base = head * REC;
            cnt  = 32'(store[base]);
            if (cnt > GSIZE) cnt = GSIZE;
            next_head = store[base + 1];
            for (k = 0; k < cnt; k++) stack_q[k] = store[base + 2 + k][7:0];
            depth = cnt;
        endfunction

        function t_alloc_result note_request(gfba_pkg::t_cmd cmd, logic [7:0] idx);
            t_alloc_result res;
            int unsigned   groups, base, top, g, j;
            res = '0;
            case (cmd)
                gfba_pkg::CMD_INIT: begin
                    groups = (group_cfg == 5'd0) ? 1 : 32'(group_cfg);
                    if (groups > NBLK / GSIZE) groups = NBLK / GSIZE;
                    for (g = 0; g < groups; g++) begin
                        base = g * GSIZE * REC;
                        store[base]     = 16'(GSIZE);
                        store[base + 1] = (g + 1 == groups) ? gfba_pkg::NO_GROUP
                                                            : 16'((g + 1) * GSIZE);
                        for (j = 0; j < GSIZE; j++) store[base + 2 + j] = 16'(g * GSIZE + j);
                    end
                    load_group(0);
                    free_total = groups * GSIZE;
                    if (free_total > NBLK) free_total = NBLK;
                    res.ok = 1'b1;
                end
                gfba_pkg::CMD_ALLOC: begin
                    res.ok = 1'b1;
                    if (depth == 0) begin
                        if (next_head >= NBLK) begin
                            res.ok = 1'b0;
                        end else begin
                            load_group(32'(next_head));
                            if (depth == 0) res.ok = 1'b0;
                        end
                    end
                    if (res.ok) begin
                        depth--;
                        res.granted = stack_q[depth];
                        if (free_total > 0) free_total--;
                    end
                end
                gfba_pkg::CMD_FREE: begin
                    // full stack: spill it as a record at the top entry's block
                    if (depth >= GSIZE) begin
                        top = 32'(stack_q[GSIZE - 1]);
                        if (top < NBLK) begin
                            base = top * REC;
                            store[base]     = 16'(GSIZE);
                            store[base + 1] = next_head;
                            for (j = 0; j < GSIZE; j++)
                                store[base + 2 + j] = {8'h00, stack_q[GSIZE - 1 - j]};
                        end
                        next_head = 16'(top);
                        depth     = 0;
                    end
                    stack_q[depth] = idx;
                    depth++;
                    if (free_total < NBLK) free_total++;
                    res.ok = 1'b1;
                end
                default: ;  // unknown command leaves the state alone, ok low
            endcase
            res.remaining = 9'(free_total);
            res.in_group  = 5'(depth);
            expected_results.push_back(res);
            return res;
        endfunction

        function void compare_field(string name, logic [8:0] want, logic [8:0] seen);
            if (seen !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(logic [7:0] granted, logic ok, logic [8:0] remaining,
                                   logic [4:0] in_group);
            t_alloc_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, got %0d/%0d/%0d/%0d",
                         $time, granted, ok, remaining, in_group);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("granted_index", 9'(want.granted), 9'(granted));
            compare_field("ok", 9'(want.ok), 9'(ok));
            compare_field("remaining_blocks", want.remaining, remaining);
            compare_field("free_in_group", 9'(want.in_group), 9'(in_group));
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [4:0] i_cfg_wr_data = gfba_pkg::GRP_CNT_RESET;
    logic       i_valid       = 1'b0;
    logic [1:0] i_command     = gfba_pkg::CMD_NONE;
    logic [7:0] i_block_index = 8'h00;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_granted_index;
    logic       o_ok;
    logic [8:0] o_remaining_blocks;
    logic [4:0] o_free_in_group;

    free_list_tracker tracker = new();
    bit               idle_en = 1'b1;
    logic [7:0]       held_blocks [$];
    int unsigned      sent = 0;

    grouped_free_block_allocator DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_command         (i_command),
        .i_block_index     (i_block_index),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_granted_index   (o_granted_index),
        .o_ok              (o_ok),
        .o_remaining_blocks(o_remaining_blocks),
        .o_free_in_group   (o_free_in_group)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                tracker.check_result(o_granted_index, o_ok, o_remaining_blocks, o_free_in_group);
            i_stall <= idle_en && ($urandom_range(99) < 18);
        end
    end

    // Returns at the edge where the request was taken.
    task automatic send_req(input gfba_pkg::t_cmd cmd, input logic [7:0] idx);
        t_alloc_result exp;
        int            gap;
        gap = 0;
        if (idle_en) begin
            while ($urandom_range(99) < 18) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_block_index <= idx;
        do @(posedge i_clk); while (o_stall);
        exp = tracker.note_request(cmd, idx);
        if (cmd == gfba_pkg::CMD_INIT) held_blocks.delete();
        if (cmd == gfba_pkg::CMD_ALLOC && exp.ok) held_blocks.push_back(exp.granted);
        sent++;
    endtask

    task automatic drain_results(input int tail);
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Only with the block idle.
    task automatic set_group_count(input logic [4:0] value);
        drain_results(4);
        i_cfg_wr_data <= value;
        i_cfg_wr_en   <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.group_cfg = value;
    endtask

    initial begin
        int unsigned    n_phase, phase_len, k, r, s, pos, alloc_pct;
        gfba_pkg::t_cmd cmd;
        logic [7:0]     idx;
        logic [4:0]     cfg_val;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(gfba_pkg::CMD_ALLOC, 8'hFF);  // nothing to hand out before init
        send_req(gfba_pkg::CMD_NONE, 8'hAA);
        send_req(gfba_pkg::CMD_FREE, 8'h00);
        set_group_count(5'd1);
        send_req(gfba_pkg::CMD_INIT, 8'h55);
        send_req(gfba_pkg::CMD_FREE, 8'hFF);   // stack full: spill
        send_req(gfba_pkg::CMD_ALLOC, 8'h00);
        send_req(gfba_pkg::CMD_ALLOC, 8'h00);  // stack empty: reload spilled record
        send_req(gfba_pkg::CMD_FREE, 8'h80);
        set_group_count(5'd0);                 // treated as one group
        send_req(gfba_pkg::CMD_INIT, 8'h00);
        repeat (17) send_req(gfba_pkg::CMD_ALLOC, 8'h00);  // last one runs dry

        n_phase = 0;
        while (sent < 1530) begin
            case (n_phase)
                0:       cfg_val = 5'd16;
                1:       cfg_val = 5'd31;
                2:       cfg_val = 5'd17;
                3:       cfg_val = 5'd2;
                4:       cfg_val = 5'd0;
                default: cfg_val = 5'($urandom_range(31));
            endcase
            set_group_count(cfg_val);
            idle_en   = (n_phase != 3);
            alloc_pct = (n_phase % 4 == 1) ? 85 : (n_phase % 4 == 3) ? 20 : 50;
            send_req(gfba_pkg::CMD_INIT, 8'($urandom_range(255)));
            phase_len = $urandom_range(80, 140);
            for (k = 0; k < phase_len; k++) begin
                r   = $urandom_range(99);
                idx = 8'($urandom_range(255));
                if (r < 2) begin
                    cmd = gfba_pkg::CMD_INIT;
                end else if (r < 5) begin
                    cmd = gfba_pkg::CMD_NONE;
                end else if (r < 5 + alloc_pct * 95 / 100) begin
                    cmd = gfba_pkg::CMD_ALLOC;
                end else begin
                    cmd = gfba_pkg::CMD_FREE;
                    s   = $urandom_range(99);
                    if (s < 55 && held_blocks.size() > 0) begin
                        pos = $urandom_range(held_blocks.size() - 1);
                        idx = held_blocks[pos];
                        held_blocks.delete(pos);
                    end else if (s < 75) begin
                        // group heads: spills onto the chain can close a loop
                        idx = 8'($urandom_range(15) * 16);
                    end
                end
                send_req(cmd, idx);
            end
            n_phase++;
        end

        drain_results(40);
        if (tracker.mismatches == 0) begin
            $display("grouped_free_block_allocator_test: done, clean");
        end else begin
            $display("grouped_free_block_allocator_test: done, errors");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("grouped_free_block_allocator_test: done, errors");
        $finish;
    end

endmodule
